// File: sv/cqd_pkg.sv
`default_nettype none

package cqd_pkg;

  localparam int unsigned CQD_DEPTH = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QSIZE_W = 6;
  localparam logic [QSIZE_W-1:0] QSIZE_RST = 6'd32;
  localparam logic [QSIZE_W-1:0] QSIZE_MIN = 6'd2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_SLOT  = 2'd0,
    KIND_OVER  = 2'd1,
    KIND_UNDER = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] slot_value;
    logic                     last;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/cqd_store.sv
`default_nettype none

module cqd_store
  import cqd_pkg::*;
#(
  parameter int unsigned DEPTH = CQD_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] slot_mem_r [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_q_r;
  logic              rd_ok_r;

  // Slots never written since reset read as zero through their valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q_r  <= slot_mem_r[raddr];
      rd_ok_r <= vld_r[raddr];
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// File: sv/cqd_ctrl.sv
`default_nettype none

module cqd_ctrl
  import cqd_pkg::*;
#(
  parameter int unsigned DEPTH = CQD_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire in_item_t                 in_item,
  output logic                          busy,
  input  wire logic                     cfg_we,
  input  wire logic [QSIZE_W-1:0]       cfg_wdata,
  output logic                          out_valid,
  output out_item_t                     out_item,
  output logic                          mem_we,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr,
  output logic      [DATA_W-1:0]        mem_wdata,
  output logic                          mem_re,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr,
  input  wire logic [DATA_W-1:0]        mem_rdata
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned SW = $clog2(DEPTH + 1);
  localparam int unsigned NW = SW + 1;
  localparam logic [QSIZE_W:0] DEPTH_CMP = (QSIZE_W + 1)'(DEPTH);

  state_t             state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic               halted_r, halted_nxt;
  logic [QSIZE_W-1:0] qsize_r, qsize_nxt;
  logic               err_vld_r, err_vld_nxt;
  kind_t              err_kind_r, err_kind_nxt;
  logic               err_last_r, err_last_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_last_r, rd_last_nxt;

  logic [SW-1:0]      size;
  logic [IW-1:0]      tail_step;
  logic [IW-1:0]      head_step;
  logic               dump_last;

  // Out-of-range sizes are clamped to the usable range of the ring.
  always_comb begin
    if ({1'b0, qsize_r} > DEPTH_CMP) begin
      size = SW'(DEPTH);
    end else if (qsize_r < QSIZE_MIN) begin
      size = SW'(QSIZE_MIN);
    end else begin
      size = SW'(qsize_r);
    end
  end

  // An index left beyond a shrunken size wraps to zero on its next step.
  assign tail_step = ((NW'(tail_r) + NW'(1)) >= NW'(size)) ? '0 : IW'(tail_r + 1'b1);
  assign head_step = ((NW'(head_r) + NW'(1)) >= NW'(size)) ? '0 : IW'(head_r + 1'b1);
  assign dump_last = (NW'(cnt_r) + NW'(1)) == NW'(size);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    halted_nxt   = halted_r;
    qsize_nxt    = cfg_we ? cfg_wdata : qsize_r;
    err_vld_nxt  = 1'b0;
    err_kind_nxt = err_kind_r;
    err_last_nxt = err_last_r;
    rd_pend_nxt  = 1'b0;
    rd_last_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = tail_step;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = cnt_r;
    busy         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start && !halted_r) begin
          case (in_item.action)
            ACT_INSERT: begin
              if (tail_step == head_r) begin
                halted_nxt   = 1'b1;
                err_vld_nxt  = 1'b1;
                err_kind_nxt = KIND_OVER;
                err_last_nxt = 1'b0;
                cnt_nxt      = '0;
                state_nxt    = ST_DUMP;
              end else begin
                tail_nxt  = tail_step;
                mem_we    = 1'b1;
                mem_waddr = tail_step;
                mem_wdata = in_item.value;
              end
            end
            ACT_REMOVE: begin
              if (tail_r == head_r) begin
                halted_nxt   = 1'b1;
                err_vld_nxt  = 1'b1;
                err_kind_nxt = KIND_UNDER;
                err_last_nxt = 1'b1;
              end else begin
                head_nxt  = head_step;
                mem_we    = 1'b1;
                mem_waddr = head_step;
              end
            end
            ACT_DUMP: begin
              cnt_nxt   = '0;
              state_nxt = ST_DUMP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        busy        = 1'b1;
        mem_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_last_nxt = dump_last;
        cnt_nxt     = IW'(cnt_r + 1'b1);
        if (dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      halted_r  <= 1'b0;
      qsize_r   <= QSIZE_RST;
      err_vld_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
      halted_r  <= halted_nxt;
      qsize_r   <= qsize_nxt;
      err_vld_r <= err_vld_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_kind_r <= err_kind_nxt;
    err_last_r <= err_last_nxt;
    rd_last_r  <= rd_last_nxt;
  end

  assign out_valid           = err_vld_r | rd_pend_r;
  assign out_item.kind       = err_vld_r ? err_kind_r : KIND_SLOT;
  assign out_item.slot_value = err_vld_r ? '0 : signed'(mem_rdata);
  assign out_item.last       = err_vld_r ? err_last_r : rd_last_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(err_vld_r && rd_pend_r))
    else $error("error result and slot result in the same cycle");

  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (NW'(cnt_r) < NW'(size)))
    else $error("dump counter ran past the ring size");

  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && dump_last) |=> (state_r == ST_IDLE && rd_last_r))
    else $error("dump did not end after its final slot");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && halted_r) |=> (!err_vld_r && state_r == ST_IDLE))
    else $error("item acted on while halted");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    err_vld_r |-> halted_r)
    else $error("error result without halt");

endmodule

`default_nettype wire

// File: sv/circular_queue_with_dump_core.sv
// Ring-buffer queue with a dump command, one slot always kept empty.
// Input channel: an item (action, value) is taken at a clock edge where start
// is high and busy is low. Insert and remove finish in the cycle they are
// taken and give no result, so one can be taken every cycle.
// A dump makes busy high while it reads every ring slot (the clamped size); slot
// results appear after the dump state and the registered slot read, one per cycle,
// in index order, the final one marked by last. The single read port of the
// slot memory sets this one-slot-per-cycle pace.
// An insert into a full ring gives an overflow result in the next cycle,
// followed directly by a dump; a remove from an empty ring gives an
// underflow result in the next cycle. After either error every item is taken
// and ignored until reset.
// Result channel: out_valid marks each result for exactly one cycle; the
// receiver cannot stall, so results are never held back.
// Configuration: cfg_we writes cfg_wdata into the size register; write it only
// while the block is idle. Sizes below 2 act as 2, above DEPTH as DEPTH.
// Reset (rst_n low, synchronous) clears the indices and the halt, sets the
// size to 32 and makes every slot read as zero at once.
`default_nettype none

module circular_queue_with_dump_core
  import cqd_pkg::*;
#(
  parameter int unsigned DEPTH = CQD_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire in_item_t             in_item,
  output logic                      busy,
  input  wire logic                 cfg_we,
  input  wire logic [QSIZE_W-1:0]   cfg_wdata,
  output logic                      out_valid,
  output out_item_t                 out_item
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  cqd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_item (out_item),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  cqd_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .rd_data(mem_rdata)
  );

endmodule

`default_nettype wire

// File: verif/circular_queue_with_dump_core_tb.sv
`timescale 1ns / 100ps

module circular_queue_with_dump_core_tb;
  import cqd_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int unsigned REPORT_CAP = 40;
  localparam int unsigned PHASE_ITEMS = 43;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 40;

  class ring_tracker;
    logic [DATA_W-1:0]  slots [CQD_DEPTH];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    bit                 halted;
    logic [QSIZE_W-1:0] size_reg;
    out_item_t          results_due [$];
    int unsigned        mismatches;
    int unsigned        results_checked;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head_idx = 0;
      tail_idx = 0;
      halted = 1'b0;
      size_reg = QSIZE_RST;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void set_size(logic [QSIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned ring_size();
      if (size_reg < QSIZE_MIN) return 32'(QSIZE_MIN);
      if (size_reg > CQD_DEPTH) return CQD_DEPTH;
      return 32'(size_reg);
    endfunction

    // An index at or past a shrunken size wraps to 0 on its next step.
    function int unsigned step(int unsigned i);
      return (i + 1 >= ring_size()) ? 0 : i + 1;
    endfunction

    function bit would_overflow();
      return step(tail_idx) == head_idx;
    endfunction

    function bit would_underflow();
      return tail_idx == head_idx;
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction

    function void expect_result(kind_t k, logic [DATA_W-1:0] v, logic is_last);
      out_item_t r;
      r.kind = k;
      r.slot_value = v;
      r.last = is_last;
      results_due.push_back(r);
    endfunction

    function void expect_dump();
      int unsigned sz;
      sz = ring_size();
      for (int unsigned i = 0; i < sz; i++)
        expect_result(KIND_SLOT, slots[i], (i + 1 == sz));
    endfunction

    // Turns an item that would halt the ring into one that keeps it running.
    function in_item_t keep_running(in_item_t it);
      in_item_t r;
      r = it;
      if (r.action == ACT_INSERT && would_overflow()) r.action = ACT_REMOVE;
      else if (r.action == ACT_REMOVE && would_underflow()) r.action = ACT_INSERT;
      return r;
    endfunction

    function void take_item(in_item_t it);
      int unsigned nx;
      if (halted) return;
      case (it.action)
        ACT_INSERT: begin
          nx = step(tail_idx);
          if (nx == head_idx) begin
            halted = 1'b1;
            expect_result(KIND_OVER, '0, 1'b0);
            expect_dump();
          end else begin
            tail_idx = nx;
            slots[nx] = it.value;
          end
        end
        ACT_REMOVE: begin
          if (tail_idx == head_idx) begin
            halted = 1'b1;
            expect_result(KIND_UNDER, '0, 1'b1);
          end else begin
            head_idx = step(head_idx);
            slots[head_idx] = '0;
          end
        end
        ACT_DUMP: expect_dump();
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t ERROR %s: expected %h, actual %h", $time, what, want, got);
      else if (mismatches == REPORT_CAP + 1)
        $display("%0t ERROR further mismatches are counted but not shown", $time);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (results_due.size() == 0) begin
        flag("unexpected result slot_value (no result pending)", '0, got.slot_value);
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind) flag("kind", DATA_W'(want.kind), DATA_W'(got.kind));
      if (got.slot_value !== want.slot_value) flag("slot_value", want.slot_value, got.slot_value);
      if (got.last !== want.last) flag("last", DATA_W'(want.last), DATA_W'(got.last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  in_item_t           in_item = '0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic [QSIZE_W-1:0] cfg_wdata = '0;
  logic               out_valid;
  out_item_t          out_item;

  ring_tracker tracker;
  int unsigned items_sent = 0;
  int unsigned size_writes = 0;

  always #5 clk = ~clk;

  circular_queue_with_dump_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tracker.match_result(out_item);
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d results still pending", tracker.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Gap odds per cycle follow the run's progress: light, heavy, then none.
  task automatic sender_gap();
    int unsigned pct;
    pct = (items_sent < 157) ? 22 : (items_sent < 314) ? 72 : 0;
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Start stays high afterwards; the next gap or settle lowers it.
  task automatic issue_item(logic [1:0] act, logic [DATA_W-1:0] v, bit guarded);
    in_item_t it;
    it.action = act;
    it.value = v;
    if (guarded) it = tracker.keep_running(it);
    sender_gap();
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_item(it);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [QSIZE_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_size(v);
    cfg_we <= 1'b0;
    size_writes++;
  endtask

  initial begin
    logic [QSIZE_W-1:0] phase_sizes [10];
    logic [1:0]         act;
    int unsigned        fill_pct;
    int unsigned        r;
    string              ending;

    tracker = new();
    phase_sizes = '{6'd0, 6'd63, 6'd5, 6'd1, 6'd33, 6'd2, 6'd32, 6'd9, 6'd17, 6'd4};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dump, extreme values, ignored action, removes.
    issue_item(ACT_DUMP, 32'h0, 1'b1);
    issue_item(ACT_INSERT, 32'h8000_0000, 1'b1);
    issue_item(ACT_INSERT, 32'h7FFF_FFFF, 1'b1);
    issue_item(ACT_INSERT, 32'h0000_0000, 1'b1);
    issue_item(ACT_INSERT, 32'hFFFF_FFFF, 1'b1);
    issue_item(ACT_INSERT, 32'h5555_5555, 1'b1);
    issue_item(ACT_INSERT, 32'hAAAA_AAAA, 1'b1);
    issue_item(ACT_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
    issue_item(ACT_DUMP, 32'hFFFF_FFFF, 1'b1);
    issue_item(ACT_REMOVE, 32'h1234_5678, 1'b1);
    issue_item(ACT_REMOVE, 32'h0, 1'b1);
    issue_item(ACT_DUMP, 32'h0, 1'b1);

    // Shrink below the live indices so both wrap on their next step.
    write_size(6'd3);
    issue_item(ACT_INSERT, 32'h0000_0001, 1'b1);
    issue_item(ACT_INSERT, 32'h0000_0002, 1'b1);
    issue_item(ACT_REMOVE, 32'h0, 1'b1);
    issue_item(ACT_DUMP, 32'h0, 1'b1);
    issue_item(ACT_INSERT, 32'hDEAD_BEEF, 1'b1);
    issue_item(ACT_INSERT, 32'hCAFE_F00D, 1'b1);
    issue_item(ACT_DUMP, 32'h0, 1'b1);

    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      fill_pct = $urandom_range(30, 65);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < fill_pct) act = ACT_INSERT;
        else if (r < 86) act = ACT_REMOVE;
        else if (r < 94) act = ACT_DUMP;
        else act = ACT_UNKNOWN;
        issue_item(act, pick_value(), 1'b1);
      end
    end

    // Only one error fits in a run, since the halt lasts until reset.
    write_size(6'd32);
    if ($urandom_range(1) == 0) begin
      ending = "an overflow with a full dump";
      while (!tracker.would_overflow()) issue_item(ACT_INSERT, pick_value(), 1'b0);
      issue_item(ACT_INSERT, pick_value(), 1'b0);
    end else begin
      ending = "an underflow";
      while (!tracker.would_underflow()) issue_item(ACT_REMOVE, pick_value(), 1'b0);
      issue_item(ACT_REMOVE, pick_value(), 1'b0);
    end
    issue_item(ACT_DUMP, 32'h0, 1'b0);
    issue_item(ACT_INSERT, pick_value(), 1'b0);
    issue_item(ACT_REMOVE, pick_value(), 1'b0);
    issue_item(ACT_UNKNOWN, pick_value(), 1'b0);

    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items across %0d size settings; %0d results compared.",
             items_sent, size_writes, tracker.results_checked);
    $display("The run ended in %s, followed by items the halted ring ignored.", ending);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: circular_queue_with_dump_core.f
sv/cqd_pkg.sv
sv/cqd_store.sv
sv/cqd_ctrl.sv
sv/circular_queue_with_dump_core.sv
verif/circular_queue_with_dump_core_tb.sv
